[rtl/fpfa_pkg.sv]
package fpfa_pkg;

    // table geometry
    localparam int MAX_PARTITIONS = 16;
    localparam int SIZE_BITS      = 16;
    localparam int IDX_W          = $clog2(MAX_PARTITIONS);
    localparam int CNT_W          = $clog2(MAX_PARTITIONS + 1);

    // configuration port
    localparam int FIT_MODE_W   = 2;
    localparam int PARTS_USE_W  = 5;
    localparam int CFG_DATA_W   = 5;

    typedef enum logic [0:0] {
        CFG_FIT_MODE     = 1'b0,
        CFG_PARTS_IN_USE = 1'b1
    } t_cfg_idx;

    // placement policy codes, any other code acts as first fit
    typedef enum logic [FIT_MODE_W-1:0] {
        FIT_FIRST = 2'd0,
        FIT_BEST  = 2'd1,
        FIT_WORST = 2'd2
    } t_fit_mode;

    // request opcodes
    typedef enum logic [0:0] {
        OP_LOAD  = 1'b0,
        OP_ALLOC = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

endpackage

[rtl/fpfa_req_if.sv]
interface fpfa_req_if;
    import fpfa_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 op;
    logic [IDX_W-1:0]     partition_index;
    logic [SIZE_BITS-1:0] request_size;

    modport source (output valid, output op, output partition_index, output request_size,
                    input ready);
    modport sink (input valid, input op, input partition_index, input request_size,
                  output ready);
endinterface

[rtl/fpfa_rsp_if.sv]
interface fpfa_rsp_if;
    import fpfa_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 granted;
    logic [IDX_W-1:0]     chosen_index;
    logic [SIZE_BITS-1:0] chosen_size;
    logic [SIZE_BITS-1:0] fragment;

    modport source (output valid, output granted, output chosen_index, output chosen_size,
                    output fragment, input ready);
    modport sink (input valid, input granted, input chosen_index, input chosen_size,
                  input fragment, output ready);
endinterface

[rtl/fpfa_ram.sv]
module fpfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/fixed_partition_fit_allocator.sv]
// Load requests give no response; the block stays idle and is ready again next cycle.
// Allocation requests read one partition size from the size RAM per cycle, for each of
// partitions_in_use partitions, then pass one compare stage behind the last read and a
// commit into the response register; with none in use the scan is skipped and the
// commit follows the accept. The next request is taken once the commit returns the block
// to idle, and a stalled response holds the commit. One request is in work at a time.
// Reset (synchronous, active low) frees all partitions and reads all sizes as zero,
// sets fit mode to first fit and partitions in use to the table depth.
module fixed_partition_fit_allocator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  fpfa_pkg::t_cfg_idx               i_cfg_idx,
    input  logic [fpfa_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    fpfa_req_if.sink                         i_req_ch,
    fpfa_rsp_if.source                       o_rsp_ch
);
    import fpfa_pkg::*;

    t_state                  r_state, n_state;
    logic [FIT_MODE_W-1:0]   r_fit_mode;
    logic [PARTS_USE_W-1:0]  r_parts_in_use;
    logic [MAX_PARTITIONS-1:0] r_loaded;
    logic [MAX_PARTITIONS-1:0] r_alloc;

    logic [SIZE_BITS-1:0]    r_req_size;
    logic [CNT_W-1:0]        r_rd_cnt;
    logic                    r_dv;
    logic                    r_cmp_last;
    logic [IDX_W-1:0]        r_cmp_idx;
    logic                    r_found;
    logic [IDX_W-1:0]        r_best_idx;
    logic [SIZE_BITS-1:0]    r_best_size;
    logic [SIZE_BITS-1:0]    r_best_left;

    logic                    r_out_valid;
    logic                    r_out_granted;
    logic [IDX_W-1:0]        r_out_index;
    logic [SIZE_BITS-1:0]    r_out_size;
    logic [SIZE_BITS-1:0]    r_out_fragment;

    logic                    w_req_ready;
    logic                    w_accept;
    logic                    w_load;
    logic                    w_alloc;
    logic                    w_issue;
    logic                    w_out_load;
    logic [CNT_W-1:0]        w_limit;
    logic [SIZE_BITS-1:0]    w_rdata;
    logic [SIZE_BITS-1:0]    w_cur_size;
    logic [SIZE_BITS-1:0]    w_left;
    logic                    w_fits;
    logic                    w_take;

    // partitions considered, saturated to the table depth
    assign w_limit = (int'(r_parts_in_use) > MAX_PARTITIONS) ? CNT_W'(MAX_PARTITIONS)
                                                             : CNT_W'(r_parts_in_use);

    assign w_accept = i_req_ch.valid && w_req_ready;
    assign w_load   = w_accept && (i_req_ch.op == OP_LOAD);
    assign w_alloc  = w_accept && (i_req_ch.op == OP_ALLOC);

    // partition size table
    fpfa_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (MAX_PARTITIONS)
    ) u_size_ram (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_waddr (i_req_ch.partition_index),
        .i_wdata (i_req_ch.request_size),
        .i_re    (w_issue),
        .i_raddr (r_rd_cnt[IDX_W-1:0]),
        .o_rdata (w_rdata)
    );

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and control
    always_comb begin
        n_state     = r_state;
        w_req_ready = 1'b0;
        w_issue     = 1'b0;
        w_out_load  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                w_req_ready = 1'b1;
                if (i_req_ch.valid && (i_req_ch.op == OP_ALLOC)) begin
                    n_state = (w_limit == '0) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                w_issue = (r_rd_cnt < w_limit);
                if (r_dv && r_cmp_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || o_rsp_ch.ready) begin
                    w_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign i_req_ch.ready = w_req_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode     <= FIT_FIRST;
            r_parts_in_use <= PARTS_USE_W'(MAX_PARTITIONS);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FIT_MODE:     r_fit_mode     <= i_cfg_data[FIT_MODE_W-1:0];
                CFG_PARTS_IN_USE: r_parts_in_use <= i_cfg_data[PARTS_USE_W-1:0];
                default: ;
            endcase
        end
    end

    // per-partition loaded and allocated flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded <= '0;
            r_alloc  <= '0;
        end else begin
            if (w_load) begin
                r_loaded[i_req_ch.partition_index] <= 1'b1;
                r_alloc[i_req_ch.partition_index]  <= 1'b0;
            end
            if (w_out_load && r_found) begin
                r_alloc[r_best_idx] <= 1'b1;
            end
        end
    end

    // compare stage on the size read back from the table
    assign w_cur_size = r_loaded[r_cmp_idx] ? w_rdata : '0;
    assign w_fits     = !r_alloc[r_cmp_idx] && (w_cur_size >= r_req_size);
    assign w_left     = w_cur_size - r_req_size;
    assign w_take     = w_fits && (!r_found
                        || ((r_fit_mode == FIT_BEST)  && (w_left < r_best_left))
                        || ((r_fit_mode == FIT_WORST) && (w_left > r_best_left)));

    // scan counter and read pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_cnt   <= '0;
            r_dv       <= 1'b0;
            r_cmp_last <= 1'b0;
            r_found    <= 1'b0;
        end else begin
            r_dv <= w_issue;
            if (w_alloc) begin
                r_rd_cnt <= '0;
                r_found  <= 1'b0;
            end else if (w_issue) begin
                r_rd_cnt   <= r_rd_cnt + 1'b1;
                r_cmp_last <= ((r_rd_cnt + 1'b1) == w_limit);
            end
            if (r_dv && w_take) begin
                r_found <= 1'b1;
            end
        end
    end

    // scan payload
    always_ff @(posedge i_clk) begin
        if (w_alloc) begin
            r_req_size <= i_req_ch.request_size;
        end
        if (w_issue) begin
            r_cmp_idx <= r_rd_cnt[IDX_W-1:0];
        end
        if (r_dv && w_take) begin
            r_best_idx  <= r_cmp_idx;
            r_best_size <= w_cur_size;
            r_best_left <= w_left;
        end
    end

    // response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_granted  <= r_found;
            r_out_index    <= r_found ? r_best_idx  : '0;
            r_out_size     <= r_found ? r_best_size : '0;
            r_out_fragment <= r_found ? r_best_left : '0;
        end
    end

    assign o_rsp_ch.valid        = r_out_valid;
    assign o_rsp_ch.granted      = r_out_granted;
    assign o_rsp_ch.chosen_index = r_out_index;
    assign o_rsp_ch.chosen_size  = r_out_size;
    assign o_rsp_ch.fragment     = r_out_fragment;
endmodule

[rtl/fpfa_checker.sv]
module fpfa_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_req_valid,
    input logic                           i_req_ready,
    input logic                           i_req_op,
    input logic                           i_rsp_valid,
    input logic                           i_rsp_ready,
    input logic                           i_rsp_granted,
    input logic [fpfa_pkg::IDX_W-1:0]     i_rsp_index,
    input logic [fpfa_pkg::SIZE_BITS-1:0] i_rsp_size,
    input logic [fpfa_pkg::SIZE_BITS-1:0] i_rsp_fragment
);
    import fpfa_pkg::*;

    // a stalled response keeps its payload
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_rsp_granted) && $stable(i_rsp_index)
             && $stable(i_rsp_size) && $stable(i_rsp_fragment)))
        else $error("response changed while stalled");

    // an allocation request blocks further requests while it scans
    a_alloc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready && (i_req_op == OP_ALLOC)) |=> !i_req_ready)
        else $error("request accepted during a scan");

    // a miss reports all-zero fields
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_granted) |->
            ((i_rsp_index == '0) && (i_rsp_size == '0) && (i_rsp_fragment == '0)))
        else $error("miss with nonzero fields");

    // the leftover never exceeds the partition size
    a_frag_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_granted) |-> (i_rsp_fragment <= i_rsp_size))
        else $error("fragment larger than partition");
endmodule

bind fixed_partition_fit_allocator fpfa_checker u_fpfa_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_valid    (i_req_ch.valid),
    .i_req_ready    (i_req_ch.ready),
    .i_req_op       (i_req_ch.op),
    .i_rsp_valid    (o_rsp_ch.valid),
    .i_rsp_ready    (o_rsp_ch.ready),
    .i_rsp_granted  (o_rsp_ch.granted),
    .i_rsp_index    (o_rsp_ch.chosen_index),
    .i_rsp_size     (o_rsp_ch.chosen_size),
    .i_rsp_fragment (o_rsp_ch.fragment)
);

[verif/tb_fixed_partition_fit_allocator.sv]
`timescale 1ns / 1ps

module tb_fixed_partition_fit_allocator;
    import fpfa_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 7;
    localparam int SETTLE_CYCLES  = MAX_PARTITIONS + 8;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int N_PHASES       = 10;

    // code outside the named policies, handled as first fit
    localparam logic [FIT_MODE_W-1:0] FIT_UNNAMED = 2'd3;

    typedef struct packed {
        logic                 granted;
        logic [IDX_W-1:0]     index;
        logic [SIZE_BITS-1:0] size;
        logic [SIZE_BITS-1:0] frag;
    } grant_t;

    typedef struct packed {
        bit                    is_cfg;
        t_cfg_idx              reg_sel;
        logic [CFG_DATA_W-1:0] reg_val;
        t_op                   op;
        logic [IDX_W-1:0]      index;
        logic [SIZE_BITS-1:0]  size;
        bit                    pinned;
        grant_t                want;
    } stim_row_t;

    // register settings walked by the random part
    logic [FIT_MODE_W-1:0] mode_plan [N_PHASES] = '{FIT_FIRST, FIT_BEST, FIT_WORST, FIT_UNNAMED,
        FIT_BEST, FIT_WORST, FIT_FIRST, FIT_BEST, FIT_WORST, FIT_UNNAMED};
    int parts_plan [N_PHASES] = '{16, 16, 16, 5, 1, 31, 0, 17, 11, 16};

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we;
    t_cfg_idx              i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    fpfa_req_if req_ch ();
    fpfa_rsp_if rsp_ch ();

    // predicted partition table and settings
    logic [SIZE_BITS-1:0]   part_size [MAX_PARTITIONS];
    bit                     part_taken [MAX_PARTITIONS];
    logic [FIT_MODE_W-1:0]  fit_mode_m;
    logic [PARTS_USE_W-1:0] parts_m;

    grant_t grant_q [$];
    bit     offer_pinned;
    grant_t offer_want;

    bit no_gaps;
    bit stall_window;
    bit long_hold_done;
    int items_sent;
    int results_seen;
    int idle_cycles;
    int errors;
    int n_loads;
    int n_allocs;
    int n_granted;
    int n_cfg_writes;

    fixed_partition_fit_allocator u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req_ch   (req_ch),
        .o_rsp_ch   (rsp_ch)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // pick a free partition by the current policy and mark it taken
    function automatic grant_t place_request(logic [SIZE_BITS-1:0] want_size);
        grant_t               g;
        int                   span;
        int                   pick;
        int                   k;
        bit                   hit;
        logic [SIZE_BITS-1:0] left;
        logic [SIZE_BITS-1:0] pick_left;
        g         = '0;
        hit       = 1'b0;
        pick      = 0;
        pick_left = '0;
        span      = (parts_m > MAX_PARTITIONS) ? MAX_PARTITIONS : int'(parts_m);
        for (k = 0; k < span; k++) begin
            if (!part_taken[k] && part_size[k] >= want_size) begin
                left = part_size[k] - want_size;
                if (!hit) begin
                    hit       = 1'b1;
                    pick      = k;
                    pick_left = left;
                end else if (fit_mode_m == FIT_BEST && left < pick_left) begin
                    pick      = k;
                    pick_left = left;
                end else if (fit_mode_m == FIT_WORST && left > pick_left) begin
                    pick      = k;
                    pick_left = left;
                end
            end
        end
        if (hit) begin
            part_taken[pick] = 1'b1;
            g.granted        = 1'b1;
            g.index          = pick[IDX_W-1:0];
            g.size           = part_size[pick];
            g.frag           = pick_left;
        end
        return g;
    endfunction

    function automatic void diff_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endfunction

    function automatic stim_row_t load_row(int idx, int sz);
        stim_row_t r;
        r       = '0;
        r.op    = OP_LOAD;
        r.index = idx[IDX_W-1:0];
        r.size  = sz[SIZE_BITS-1:0];
        return r;
    endfunction

    function automatic stim_row_t alloc_row(int sz, int idx);
        stim_row_t r;
        r       = '0;
        r.op    = OP_ALLOC;
        r.index = idx[IDX_W-1:0];
        r.size  = sz[SIZE_BITS-1:0];
        return r;
    endfunction

    function automatic stim_row_t cfg_row(t_cfg_idx which, int val);
        stim_row_t r;
        r         = '0;
        r.is_cfg  = 1'b1;
        r.reg_sel = which;
        r.reg_val = val[CFG_DATA_W-1:0];
        return r;
    endfunction

    // attach a hand-written response to a row
    function automatic stim_row_t pin(stim_row_t r, int g, int idx, int sz, int frag);
        stim_row_t p;
        p              = r;
        p.pinned       = 1'b1;
        p.want.granted = g[0];
        p.want.index   = idx[IDX_W-1:0];
        p.want.size    = sz[SIZE_BITS-1:0];
        p.want.frag    = frag[SIZE_BITS-1:0];
        return p;
    endfunction

    function automatic logic [SIZE_BITS-1:0] draw_size(int style);
        case (style)
            0:       return SIZE_BITS'($urandom_range(0, 15));
            1:       return SIZE_BITS'($urandom_range(0, 1023));
            2:       return SIZE_BITS'($urandom_range(0, 65535));
            default: return $urandom_range(0, 1) ? '1 : '0;
        endcase
    endfunction

    // mostly back to back, sometimes short gaps, rarely long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // offer one request and hold it until accepted
    task automatic send_item(stim_row_t r);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid           <= 1'b1;
        req_ch.op              <= r.op;
        req_ch.partition_index <= r.index;
        req_ch.request_size    <= r.size;
        offer_pinned           <= r.pinned;
        offer_want             <= r.want;
        do @(posedge i_clk); while (!(req_ch.valid && req_ch.ready));
        items_sent++;
    endtask

    // stop offering and wait for every outstanding response
    task automatic drain_results();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (grant_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx which, logic [CFG_DATA_W-1:0] val);
        drain_results();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= which;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (which == CFG_FIT_MODE)
            fit_mode_m = val[FIT_MODE_W-1:0];
        else
            parts_m = val;
        n_cfg_writes++;
    endtask

    // response ready with random stalls and one long hold-off
    initial begin : rsp_ready_drive
        int stall;
        int steady;
        int roll;
        stall        = 0;
        steady       = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_window && !long_hold_done) begin
                rsp_ch.ready   <= 1'b0;
                long_hold_done = 1'b1;
                repeat (LONG_HOLD) @(negedge i_clk);
            end else if (steady > 0) begin
                rsp_ch.ready <= 1'b1;
                steady--;
            end else if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                stall--;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 60) begin
                    rsp_ch.ready <= 1'b1;
                end else if (roll < 90) begin
                    rsp_ch.ready <= 1'b0;
                    stall        = $urandom_range(0, 2);
                end else if (roll < 96) begin
                    rsp_ch.ready <= 1'b0;
                    stall        = $urandom_range(10, 40);
                end else begin
                    rsp_ch.ready <= 1'b1;
                    steady       = $urandom_range(50, 150);
                end
            end
        end
    end

    // predict on each accepted request, check each accepted response
    always @(posedge i_clk) begin : scoreboard
        grant_t seen;
        grant_t want;
        bit     moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (rsp_ch.valid && rsp_ch.ready) begin
                moved = 1'b1;
                results_seen++;
                seen = {rsp_ch.granted, rsp_ch.chosen_index, rsp_ch.chosen_size,
                        rsp_ch.fragment};
                if (grant_q.size() == 0) begin
                    $error("response with no allocation request outstanding");
                    errors++;
                end else begin
                    want = grant_q.pop_front();
                    diff_field("granted", 32'(want.granted), 32'(seen.granted));
                    diff_field("chosen_index", 32'(want.index), 32'(seen.index));
                    diff_field("chosen_size", 32'(want.size), 32'(seen.size));
                    diff_field("fragment", 32'(want.frag), 32'(seen.frag));
                end
            end
            if (req_ch.valid && req_ch.ready) begin
                moved = 1'b1;
                if (req_ch.op == OP_LOAD) begin
                    part_size[req_ch.partition_index]  = req_ch.request_size;
                    part_taken[req_ch.partition_index] = 1'b0;
                    n_loads++;
                end else begin
                    want = place_request(req_ch.request_size);
                    if (offer_pinned)
                        want = offer_want;
                    grant_q.push_back(want);
                    n_allocs++;
                    if (want.granted)
                        n_granted++;
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no request or response moved for %0d cycles", idle_cycles);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin : stimulus
        stim_row_t            dir_rows [$];
        stim_row_t            r;
        logic [SIZE_BITS-1:0] base;
        logic [SIZE_BITS-1:0] sz;
        int                   ph;
        int                   phase_start;
        int                   budget;
        int                   span;
        int                   style;
        int                   k;
        bit                   paused_mid;

        // inputs known from time zero, table and settings as after reset
        req_ch.valid           = 1'b0;
        req_ch.op              = OP_LOAD;
        req_ch.partition_index = '0;
        req_ch.request_size    = '0;
        i_cfg_we               = 1'b0;
        i_cfg_idx              = CFG_FIT_MODE;
        i_cfg_data             = '0;
        offer_pinned           = 1'b0;
        offer_want             = '0;
        fit_mode_m             = FIT_FIRST;
        parts_m                = PARTS_USE_W'(MAX_PARTITIONS);
        paused_mid             = 1'b0;
        for (k = 0; k < MAX_PARTITIONS; k++) begin
            part_size[k]  = '0;
            part_taken[k] = 1'b0;
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset table, extremes, each policy, odd register values
        dir_rows.push_back(pin(alloc_row(0, 15), 1, 0, 0, 0));
        dir_rows.push_back(pin(alloc_row(1, 0), 0, 0, 0, 0));
        dir_rows.push_back(load_row(15, 65535));
        dir_rows.push_back(pin(alloc_row(65535, 0), 1, 15, 65535, 0));
        dir_rows.push_back(alloc_row(0, 10));
        dir_rows.push_back(load_row(0, 100));
        dir_rows.push_back(load_row(1, 300));
        dir_rows.push_back(load_row(2, 200));
        dir_rows.push_back(load_row(3, 150));
        dir_rows.push_back(alloc_row(120, 0));
        dir_rows.push_back(cfg_row(CFG_FIT_MODE, FIT_BEST));
        dir_rows.push_back(alloc_row(120, 0));
        dir_rows.push_back(cfg_row(CFG_FIT_MODE, FIT_WORST));
        dir_rows.push_back(load_row(1, 300));
        dir_rows.push_back(alloc_row(10, 0));
        dir_rows.push_back(cfg_row(CFG_FIT_MODE, FIT_UNNAMED));
        dir_rows.push_back(alloc_row(10, 0));
        dir_rows.push_back(cfg_row(CFG_PARTS_IN_USE, 0));
        dir_rows.push_back(pin(alloc_row(0, 0), 0, 0, 0, 0));
        dir_rows.push_back(cfg_row(CFG_PARTS_IN_USE, 1));
        dir_rows.push_back(load_row(0, 0));
        dir_rows.push_back(pin(alloc_row(0, 0), 1, 0, 0, 0));
        dir_rows.push_back(alloc_row(0, 0));
        dir_rows.push_back(cfg_row(CFG_PARTS_IN_USE, 31));
        dir_rows.push_back(alloc_row(65535, 0));
        dir_rows.push_back(load_row(15, 65535));
        dir_rows.push_back(alloc_row(65535, 0));
        dir_rows.push_back(cfg_row(CFG_PARTS_IN_USE, 17));
        dir_rows.push_back(alloc_row(0, 0));
        dir_rows.push_back(cfg_row(CFG_FIT_MODE, FIT_BEST));
        dir_rows.push_back(load_row(5, 50));
        dir_rows.push_back(load_row(6, 50));
        dir_rows.push_back(alloc_row(50, 0));

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg)
                write_reg(dir_rows[i].reg_sel, dir_rows[i].reg_val);
            else
                send_item(dir_rows[i]);
        end

        // random: load a set of partitions, then allocate against their sizes
        for (ph = 0; ph < N_PHASES; ph++) begin
            write_reg(CFG_FIT_MODE, CFG_DATA_W'(mode_plan[ph]));
            write_reg(CFG_PARTS_IN_USE, parts_plan[ph][CFG_DATA_W-1:0]);
            no_gaps     = (ph % 3 == 1);
            budget      = (parts_plan[ph] == 0) ? 20 : 120;
            span        = (parts_plan[ph] == 0 || parts_plan[ph] > MAX_PARTITIONS) ?
                          MAX_PARTITIONS : parts_plan[ph];
            phase_start = items_sent;
            while (items_sent - phase_start < budget) begin
                // keep offering through the long response hold-off
                if (ph == 2 && items_sent - phase_start >= 20)
                    stall_window = 1'b1;
                if (ph == 4 && items_sent - phase_start >= 60 && !paused_mid) begin
                    paused_mid = 1'b1;
                    drain_results();
                end
                if ($urandom_range(0, 99) < 15) begin
                    // noise: any opcode, index and size
                    r       = '0;
                    r.op    = t_op'($urandom_range(0, 1));
                    r.index = IDX_W'($urandom_range(0, MAX_PARTITIONS - 1));
                    r.size  = SIZE_BITS'($urandom_range(0, 65535));
                    send_item(r);
                end else begin
                    style = $urandom_range(0, 3);
                    repeat ($urandom_range(1, span)) begin
                        k = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_PARTITIONS - 1)
                                                        : $urandom_range(0, span - 1);
                        send_item(load_row(k, draw_size(style)));
                    end
                    repeat ($urandom_range(1, span + 2)) begin
                        base = part_size[$urandom_range(0, MAX_PARTITIONS - 1)];
                        case ($urandom_range(0, 9))
                            0, 1, 2, 3: sz = base;
                            4, 5:       sz = (base > 8) ? SIZE_BITS'(base - $urandom_range(1, 8))
                                                        : '0;
                            6:          sz = (base < 16'hFFF0)
                                             ? SIZE_BITS'(base + $urandom_range(1, 8)) : base;
                            7, 8:       sz = draw_size(style);
                            default:    sz = '0;
                        endcase
                        send_item(alloc_row(sz, $urandom_range(0, MAX_PARTITIONS - 1)));
                    end
                end
            end
        end

        drain_results();
        if (grant_q.size() != 0) begin
            $error("%0d allocation responses never arrived", grant_q.size());
            errors++;
        end

        $display("run covered %0d loads and %0d allocation requests, %0d granted, %0d no fit",
                 n_loads, n_allocs, n_granted, n_allocs - n_granted);
        $display("%0d responses checked across %0d register writes: all four fit codes, %s",
                 results_seen, n_cfg_writes, "0 to 31 partitions in use");
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
